/* rtl/rmts_pkg.sv */
// Package for the rate-monotonic tick scheduler: widths, codes and the
// structs shared by the task cells and the top level. No dependencies.
package rmts_pkg;

    localparam int MAX_TASKS = 8;
    localparam int IDX_W     = 3;   // task index, matches the slot field
    localparam int CNT_W     = 4;   // active task count register
    localparam int TIME_W    = 32;
    localparam int VAL_W     = 16;

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_LOAD = 1'b1;

    localparam logic PASS_REL = 1'b0;   // release pass
    localparam logic PASS_SEL = 1'b1;   // late check and selection pass

    localparam logic REG_ACTIVE_TASKS = 1'b0;
    localparam logic REG_HORIZON      = 1'b1;

    // Data that travels from one cell to the next with the scan token.
    typedef struct packed {
        logic              tok;
        logic              pass;
        logic              miss;
        logic [IDX_W-1:0]  miss_idx;
        logic              found;
        logic [IDX_W-1:0]  best_idx;
        logic [VAL_W-1:0]  best_period;
        logic [VAL_W-1:0]  best_rem;
        logic [TIME_W-1:0] best_jdl;
    } t_rmts_link;

    // Commands and context broadcast from the controller to every cell.
    typedef struct packed {
        logic [TIME_W-1:0] now;
        logic [CNT_W-1:0]  n_act;
        logic              load;
        logic [IDX_W-1:0]  slot;
        logic [VAL_W-1:0]  period;
        logic [VAL_W-1:0]  work;
        logic [VAL_W-1:0]  deadline;
        logic [VAL_W-1:0]  first_release;
        logic              dec;
        logic [IDX_W-1:0]  dec_idx;
    } t_rmts_bcast;

    typedef struct packed {
        logic [TIME_W-1:0] tick_time;
        logic              ran;
        logic [IDX_W-1:0]  ran_task;
        logic              job_finished;
        logic              missed;
        logic [IDX_W-1:0]  missed_task;
        logic              stopped;
    } t_rmts_res;

endpackage

/* rtl/rmts_cell.sv */
// One task cell of the scheduler chain: holds one task's table entry and
// job state, and forwards the scan token and running results. Uses rmts_pkg.
module rmts_cell
    import rmts_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [IDX_W-1:0] i_idx,
    input  t_rmts_bcast      i_bc,
    input  t_rmts_link       i_link,
    output t_rmts_link       o_link
);

    logic [VAL_W-1:0]  r_period, n_period;
    logic [VAL_W-1:0]  r_work, n_work;
    logic [VAL_W-1:0]  r_dl, n_dl;
    logic [VAL_W-1:0]  r_rem, n_rem;
    logic [TIME_W-1:0] r_jdl, n_jdl;
    logic [TIME_W-1:0] r_nrel, n_nrel;
    t_rmts_link        r_link, n_link;
    logic              w_act;
    logic              w_here;

    assign w_act  = ({{(CNT_W-IDX_W){1'b0}}, i_idx} < i_bc.n_act);
    assign w_here = i_link.tok & w_act & ~i_link.miss;

    always_comb begin
        n_period = r_period;
        n_work   = r_work;
        n_dl     = r_dl;
        n_rem    = r_rem;
        n_jdl    = r_jdl;
        n_nrel   = r_nrel;
        n_link   = i_link;
        if (i_bc.load && (i_bc.slot == i_idx)) begin
            n_period = i_bc.period;
            n_work   = i_bc.work;
            n_dl     = i_bc.deadline;
            n_nrel   = {{(TIME_W-VAL_W){1'b0}}, i_bc.first_release};
            n_rem    = '0;
            n_jdl    = {{(TIME_W-VAL_W){1'b0}}, i_bc.first_release}
                     + {{(TIME_W-VAL_W){1'b0}}, i_bc.deadline};
        end else if (i_bc.dec && (i_bc.dec_idx == i_idx)) begin
            n_rem = r_rem - VAL_W'(1);
        end else if (w_here) begin
            case (i_link.pass)
                PASS_REL: begin
                    if (r_nrel == i_bc.now) begin
                        if (r_rem != '0) begin
                            // The previous job is still unfinished.
                            n_link.miss     = 1'b1;
                            n_link.miss_idx = i_idx;
                        end else begin
                            n_rem  = r_work;
                            n_jdl  = i_bc.now + {{(TIME_W-VAL_W){1'b0}}, r_dl};
                            n_nrel = r_nrel + {{(TIME_W-VAL_W){1'b0}}, r_period};
                        end
                    end
                end
                PASS_SEL: begin
                    if ((r_rem != '0) && (r_jdl <= i_bc.now)) begin
                        n_link.miss     = 1'b1;
                        n_link.miss_idx = i_idx;
                        n_rem           = '0;
                    end else if ((r_rem != '0) &&
                                 (!i_link.found || (r_period < i_link.best_period))) begin
                        n_link.found       = 1'b1;
                        n_link.best_idx    = i_idx;
                        n_link.best_period = r_period;
                        n_link.best_rem    = r_rem;
                        n_link.best_jdl    = r_jdl;
                    end
                end
                default: begin
                    n_link = i_link;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem  <= '0;
            r_jdl  <= '0;
            r_nrel <= '0;
            r_link <= '0;
        end else begin
            r_rem  <= n_rem;
            r_jdl  <= n_jdl;
            r_nrel <= n_nrel;
            r_link <= n_link;
        end
    end

    always_ff @(posedge i_clk) begin
        r_period <= n_period;
        r_work   <= n_work;
        r_dl     <= n_dl;
    end

    assign o_link = r_link;

endmodule

/* rtl/rate_monotonic_tick_scheduler_core.sv */
// Top level of the rate-monotonic tick scheduler: controller, configuration
// registers, result buffering and the chain of task cells. Uses rmts_pkg, rmts_cell.
//
//  Channel   Direction  Handshake                  Payload
//  input     in         i_in_valid / o_in_stall    opcode, slot, period, work_ticks,
//                                                  relative_deadline, first_release
//  result    out        o_out_valid / i_out_stall  tick_time, ran, ran_task,
//                                                  job_finished, missed, missed_task, stopped
//  config    in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// A load or an ignored tick fills the result slot at its transfer. A scheduled tick
// sends a token down the MAX_TASKS cells, one cell per cycle, for the release pass and,
// unless that pass finds a miss, once more for late check and selection; its result
// then waits in the pending slot until the output register is free.
// Synchronous active-low reset clears job state, time, halt flag and the active count,
// sets the horizon to all ones and leaves the task table as it is. The input stalls
// while a tick is in the chain or a result awaits the output.
module rate_monotonic_tick_scheduler_core
    import rmts_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // item input
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic              i_opcode,
    input  logic [IDX_W-1:0]  i_slot,
    input  logic [VAL_W-1:0]  i_period,
    input  logic [VAL_W-1:0]  i_work_ticks,
    input  logic [VAL_W-1:0]  i_relative_deadline,
    input  logic [VAL_W-1:0]  i_first_release,
    // result output
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [TIME_W-1:0] o_tick_time,
    output logic              o_ran,
    output logic [IDX_W-1:0]  o_ran_task,
    output logic              o_job_finished,
    output logic              o_missed,
    output logic [IDX_W-1:0]  o_missed_task,
    output logic              o_stopped,
    // configuration writes
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic              i_cfg_index,
    input  logic [TIME_W-1:0] i_cfg_data
);

    // Control and configuration state.
    logic              r_busy, n_busy;
    logic              r_halted, n_halted;
    logic [TIME_W-1:0] r_now, n_now;
    logic [CNT_W-1:0]  r_active;
    logic [TIME_W-1:0] r_horizon;

    // Finished result waiting for the output register, and the output register.
    logic              r_pend_valid, n_pend_valid;
    t_rmts_res         r_pend, n_pend;
    logic              r_out_valid;
    t_rmts_res         r_out;

    logic              w_in_xfer;
    logic              w_is_load;
    logic              w_ignored;
    logic              w_start;
    logic              w_pend_move;
    logic              w_end_rel;
    logic              w_end_sel;
    logic              w_dec;
    logic              w_overrun;
    logic [VAL_W-1:0]  w_rem_left;
    logic [TIME_W-1:0] w_now_inc;
    logic [CNT_W-1:0]  w_n_sat;
    t_rmts_bcast       w_bc;
    t_rmts_link        w_link [MAX_TASKS+1];
    t_rmts_link        w_tail;
    t_rmts_res         w_zero_res;
    logic [MAX_TASKS-1:0] w_tok_vec;

    // The input is taken only when the chain is empty and no result is queued,
    // so a tick's result always finds the pending slot free.
    assign o_in_stall  = r_busy | r_pend_valid;
    assign w_in_xfer   = i_in_valid & ~o_in_stall;
    assign w_is_load   = (i_opcode == OP_LOAD);
    assign w_ignored   = r_halted | (r_now >= r_horizon);
    assign w_start     = w_in_xfer & ~w_is_load & ~w_ignored;
    assign w_pend_move = r_pend_valid & (~r_out_valid | ~i_out_stall);

    assign o_cfg_ready = 1'b1;

    assign w_n_sat = (r_active > CNT_W'(MAX_TASKS)) ? CNT_W'(MAX_TASKS) : r_active;

    // The token leaving the last cell ends a pass.
    assign w_tail    = w_link[MAX_TASKS];
    assign w_end_rel = w_tail.tok & (w_tail.pass == PASS_REL);
    assign w_end_sel = w_tail.tok & (w_tail.pass == PASS_SEL);

    // The chosen task runs for one tick; its cell decrements its own work count
    // at the same edge at which the result is taken.
    assign w_rem_left = w_tail.best_rem - VAL_W'(1);
    assign w_now_inc  = r_now + TIME_W'(1);
    assign w_overrun  = ({1'b0, r_now} + {{TIME_W{1'b0}}, 1'b1}) > {1'b0, w_tail.best_jdl};
    assign w_dec      = w_end_sel & ~w_tail.miss & w_tail.found;

    // Head of the chain: a fresh release pass on a scheduled tick, or the
    // selection pass right after a release pass that found no miss.
    always_comb begin
        w_link[0]      = '0;
        w_link[0].tok  = w_start | (w_end_rel & ~w_tail.miss);
        w_link[0].pass = w_start ? PASS_REL : PASS_SEL;
    end

    always_comb begin
        w_bc               = '0;
        w_bc.now           = r_now;
        w_bc.n_act         = w_n_sat;
        w_bc.load          = w_in_xfer & w_is_load;
        w_bc.slot          = i_slot;
        w_bc.period        = i_period;
        w_bc.work          = i_work_ticks;
        w_bc.deadline      = i_relative_deadline;
        w_bc.first_release = i_first_release;
        w_bc.dec           = w_dec;
        w_bc.dec_idx       = w_tail.best_idx;
    end

    for (genvar k = 0; k < MAX_TASKS; k++) begin : g_cell
        rmts_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_idx   (IDX_W'(k)),
            .i_bc    (w_bc),
            .i_link  (w_link[k]),
            .o_link  (w_link[k+1])
        );
        assign w_tok_vec[k] = w_link[k+1].tok;
    end

    // Sequencing of one item and the result it produces.
    always_comb begin
        w_zero_res   = '0;
        n_busy       = r_busy;
        n_halted     = r_halted;
        n_now        = r_now;
        n_pend       = r_pend;
        n_pend_valid = r_pend_valid & ~w_pend_move;

        if (w_in_xfer && (w_is_load || w_ignored)) begin
            // Loads and ignored ticks change no schedule state.
            n_pend           = w_zero_res;
            n_pend.tick_time = w_is_load ? '0 : r_now;
            n_pend.stopped   = r_halted;
            n_pend_valid     = 1'b1;
        end else if (w_start) begin
            n_busy = 1'b1;
        end else if (w_end_rel && w_tail.miss) begin
            // A task was released while its previous job was still pending.
            n_busy             = 1'b0;
            n_halted           = 1'b1;
            n_pend             = w_zero_res;
            n_pend.tick_time   = r_now;
            n_pend.missed      = 1'b1;
            n_pend.missed_task = w_tail.miss_idx;
            n_pend.stopped     = 1'b1;
            n_pend_valid       = 1'b1;
        end else if (w_end_sel) begin
            n_busy           = 1'b0;
            n_pend_valid     = 1'b1;
            n_pend           = w_zero_res;
            n_pend.tick_time = r_now;
            if (w_tail.miss) begin
                // A pending job has reached its deadline.
                n_halted           = 1'b1;
                n_pend.missed      = 1'b1;
                n_pend.missed_task = w_tail.miss_idx;
                n_pend.stopped     = 1'b1;
            end else if (!w_tail.found) begin
                n_now = w_now_inc;
            end else begin
                n_pend.ran      = 1'b1;
                n_pend.ran_task = w_tail.best_idx;
                if (w_rem_left == '0) begin
                    n_pend.job_finished = 1'b1;
                    n_now               = w_now_inc;
                end else if (w_overrun) begin
                    // Work is left but the deadline passes with this tick.
                    n_halted           = 1'b1;
                    n_pend.missed      = 1'b1;
                    n_pend.missed_task = w_tail.best_idx;
                    n_pend.stopped     = 1'b1;
                end else begin
                    n_now = w_now_inc;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy       <= 1'b0;
            r_halted     <= 1'b0;
            r_now        <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
            r_active     <= '0;
            r_horizon    <= '1;
        end else begin
            r_busy       <= n_busy;
            r_halted     <= n_halted;
            r_now        <= n_now;
            r_pend_valid <= n_pend_valid;
            if (w_pend_move) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_ACTIVE_TASKS: r_active  <= i_cfg_data[CNT_W-1:0];
                    REG_HORIZON:      r_horizon <= i_cfg_data;
                    default:          r_horizon <= r_horizon;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend <= n_pend;
        if (w_pend_move) begin
            r_out <= r_pend;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_tick_time    = r_out.tick_time;
    assign o_ran          = r_out.ran;
    assign o_ran_task     = r_out.ran_task;
    assign o_job_finished = r_out.job_finished;
    assign o_missed       = r_out.missed;
    assign o_missed_task  = r_out.missed_task;
    assign o_stopped      = r_out.stopped;

    // Only one scan token is ever in the chain.
    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_tok_vec))
        else $error("more than one scan token in the task chain");

    // A token in the chain always belongs to a tick in progress.
    a_token_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (|w_tok_vec) |-> r_busy)
        else $error("scan token present while the controller is idle");

    // A tick in progress never finds its result slot occupied.
    a_pend_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_busy && r_pend_valid))
        else $error("result queued while a tick is still in the chain");

    // Once halted, time stands still.
    a_halt_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |=> $stable(r_now))
        else $error("time advanced after a halt");

endmodule

/* bench/rmts_sched_check_pkg.sv */
// Checking side of the rate-monotonic tick scheduler bench: the item and
// scheduler state types, the schedule predictor and the result scoreboard.
// Depends on rmts_pkg for widths, codes and the result struct.
package rmts_sched_check_pkg;
    import rmts_pkg::*;

    // One input item as the bench sends it.
    typedef struct packed {
        logic             opcode;
        logic [IDX_W-1:0] slot;
        logic [VAL_W-1:0] period;
        logic [VAL_W-1:0] work;
        logic [VAL_W-1:0] deadline;
        logic [VAL_W-1:0] first_release;
    } t_sched_item;

    // Everything the scheduler remembers, registers included.
    typedef struct packed {
        logic [MAX_TASKS-1:0][VAL_W-1:0]  period;
        logic [MAX_TASKS-1:0][VAL_W-1:0]  work;
        logic [MAX_TASKS-1:0][VAL_W-1:0]  deadline;
        logic [MAX_TASKS-1:0][VAL_W-1:0]  remaining;
        logic [MAX_TASKS-1:0][TIME_W-1:0] job_dl;
        logic [MAX_TASKS-1:0][TIME_W-1:0] next_rel;
        logic [TIME_W-1:0]                now;
        logic                             halted;
        logic [CNT_W-1:0]                 active;
        logic [TIME_W-1:0]                horizon;
    } t_sched_state;

    class rmts_sched_checker;
        t_sched_state st;
        t_rmts_res    predicted_reports[$];
        int unsigned  failures;
        int unsigned  checked;

        function new();
            st = '0;
            st.horizon = '1;
            failures = 0;
            checked = 0;
        endfunction

        // Advances the scheduler by one item and returns the report it produces.
        static function t_rmts_res schedule_step(inout t_sched_state s, input t_sched_item it);
            t_rmts_res         r;
            int                n;
            logic              found;
            logic [IDX_W-1:0]  best;
            logic [VAL_W-1:0]  best_period;
            logic [TIME_W-1:0] t;
            r = '0;
            found = 1'b0;
            best = '0;
            best_period = '0;
            if (it.opcode == OP_LOAD) begin
                s.period[it.slot]    = it.period;
                s.work[it.slot]      = it.work;
                s.deadline[it.slot]  = it.deadline;
                s.next_rel[it.slot]  = {16'b0, it.first_release};
                s.remaining[it.slot] = '0;
                s.job_dl[it.slot]    = {16'b0, it.first_release} + {16'b0, it.deadline};
                r.stopped = s.halted;
                return r;
            end
            t = s.now;
            r.tick_time = t;
            if (s.halted || t >= s.horizon) begin
                r.stopped = s.halted;
                return r;
            end
            n = (s.active > MAX_TASKS) ? MAX_TASKS : int'(s.active);
            // Releases, in index order; a job still running at its next release
            // is a miss and stops the scan right there.
            for (int i = 0; i < n; i++) begin
                if (s.next_rel[i] == t) begin
                    if (s.remaining[i] != 0) begin
                        s.halted = 1'b1;
                        r.missed = 1'b1;
                        r.missed_task = i[IDX_W-1:0];
                        r.stopped = 1'b1;
                        return r;
                    end
                    s.remaining[i] = s.work[i];
                    s.job_dl[i]    = t + {16'b0, s.deadline[i]};
                    s.next_rel[i]  = s.next_rel[i] + {16'b0, s.period[i]};
                end
            end
            // Pending jobs whose deadline has already come.
            for (int i = 0; i < n; i++) begin
                if (s.remaining[i] != 0 && s.job_dl[i] <= t) begin
                    s.remaining[i] = '0;
                    s.halted = 1'b1;
                    r.missed = 1'b1;
                    r.missed_task = i[IDX_W-1:0];
                    r.stopped = 1'b1;
                    return r;
                end
            end
            // Shortest period wins, the lower index on a tie.
            for (int i = 0; i < n; i++) begin
                if (s.remaining[i] != 0 && (!found || s.period[i] < best_period)) begin
                    found = 1'b1;
                    best = i[IDX_W-1:0];
                    best_period = s.period[i];
                end
            end
            if (!found) begin
                s.now = t + 1;
                return r;
            end
            s.remaining[best] = s.remaining[best] - 1'b1;
            r.ran = 1'b1;
            r.ran_task = best;
            if (s.remaining[best] == 0) begin
                r.job_finished = 1'b1;
                s.now = t + 1;
                return r;
            end
            if (({1'b0, t} + 33'd1) > {1'b0, s.job_dl[best]}) begin
                s.halted = 1'b1;
                r.missed = 1'b1;
                r.missed_task = best;
                r.stopped = 1'b1;
                return r;
            end
            s.now = t + 1;
            return r;
        endfunction

        static function string describe(t_rmts_res r);
            return $sformatf({"time=%0d ran=%0b ran_task=%0d finished=%0b ",
                              "missed=%0b missed_task=%0d stopped=%0b"},
                             r.tick_time, r.ran, r.ran_task, r.job_finished, r.missed,
                             r.missed_task, r.stopped);
        endfunction

        // What the next item would report, without touching the state.
        function t_rmts_res preview(t_sched_item it);
            t_sched_state scratch;
            scratch = st;
            return schedule_step(scratch, it);
        endfunction

        function void write_reg(logic idx, logic [TIME_W-1:0] data);
            if (idx == REG_ACTIVE_TASKS)
                st.active = data[CNT_W-1:0];
            else
                st.horizon = data;
        endfunction

        // Notes an accepted item; returns 1 unless the block just ignores it.
        function bit note_accepted_item(t_sched_item it);
            bit counts;
            counts = (it.opcode == OP_LOAD) || (!st.halted && st.now < st.horizon);
            predicted_reports.push_back(schedule_step(st, it));
            return counts;
        endfunction

        function void check_tick_result(t_rmts_res got);
            t_rmts_res want;
            checked++;
            if (predicted_reports.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("result %0d arrived with nothing predicted: %s",
                             checked, describe(got));
                return;
            end
            want = predicted_reports.pop_front();
            if (got.tick_time !== want.tick_time || got.ran !== want.ran ||
                got.ran_task !== want.ran_task || got.job_finished !== want.job_finished ||
                got.missed !== want.missed || got.missed_task !== want.missed_task ||
                got.stopped !== want.stopped) begin
                failures++;
                if (failures <= 10) begin
                    $display("result %0d mismatch", checked);
                    $display("  expected %s", describe(want));
                    $display("  actual   %s", describe(got));
                end
            end
        endfunction

        function int pending();
            return predicted_reports.size();
        endfunction

        function void close_out();
            if (predicted_reports.size() != 0) begin
                $display("%0d predicted results never arrived", predicted_reports.size());
                failures += predicted_reports.size();
            end
        endfunction
    endclass

endpackage

/* bench/rate_monotonic_tick_scheduler_core_tb.sv */
// Bench top for the rate-monotonic tick scheduler: drives loads, ticks and
// register writes, and checks every result against rmts_sched_check_pkg.
// Depends on rmts_pkg, rmts_sched_check_pkg and rate_monotonic_tick_scheduler_core.
module rate_monotonic_tick_scheduler_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rmts_pkg::*;
    import rmts_sched_check_pkg::*;

    localparam int ITEM_TARGET     = 2000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int WATCHDOG_LIMIT  = 5000;
    // Wait at the end; leaves ample margin for a scheduled tick to finish.
    localparam int SETTLE_CYCLES   = 4 * MAX_TASKS + 8;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_stall;
    logic              i_opcode = OP_TICK;
    logic [IDX_W-1:0]  i_slot = '0;
    logic [VAL_W-1:0]  i_period = '0;
    logic [VAL_W-1:0]  i_work_ticks = '0;
    logic [VAL_W-1:0]  i_relative_deadline = '0;
    logic [VAL_W-1:0]  i_first_release = '0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    logic [TIME_W-1:0] o_tick_time;
    logic              o_ran;
    logic [IDX_W-1:0]  o_ran_task;
    logic              o_job_finished;
    logic              o_missed;
    logic [IDX_W-1:0]  o_missed_task;
    logic              o_stopped;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic              i_cfg_index = REG_ACTIVE_TASKS;
    logic [TIME_W-1:0] i_cfg_data = '0;

    rate_monotonic_tick_scheduler_core uut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_stall          (o_in_stall),
        .i_opcode            (i_opcode),
        .i_slot              (i_slot),
        .i_period            (i_period),
        .i_work_ticks        (i_work_ticks),
        .i_relative_deadline (i_relative_deadline),
        .i_first_release     (i_first_release),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_tick_time         (o_tick_time),
        .o_ran               (o_ran),
        .o_ran_task          (o_ran_task),
        .o_job_finished      (o_job_finished),
        .o_missed            (o_missed),
        .o_missed_task       (o_missed_task),
        .o_stopped           (o_stopped),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data)
    );

    rmts_sched_checker sb = new();

    // While this is set, a tick that the schedule predicts to miss is replaced
    // by a fresh load of the offending slot. A miss halts the block for good,
    // and reset is applied only once, so misses are saved for the very end.
    bit          avoid_halt = 1'b1;
    int unsigned items_done = 0;
    int unsigned hold_requests = 0;

    // Receiver state.
    int unsigned hold_seen = 0;
    int          hold_left = 0;
    int          stall_mode = 0;
    int          mode_left = 0;
    t_rmts_res   seen_report;

    int unsigned idle_cycles = 0;

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Item side
    // ------------------------------------------------------------------

    // Offers one item and holds it until the transfer happens. Valid is left
    // high, so back-to-back items keep it up without a glitch; whoever idles
    // the channel lowers it.
    task automatic push_item(input t_sched_item it);
        i_in_valid          <= 1'b1;
        i_opcode            <= it.opcode;
        i_slot              <= it.slot;
        i_period            <= it.period;
        i_work_ticks        <= it.work;
        i_relative_deadline <= it.deadline;
        i_first_release     <= it.first_release;
        do @(posedge i_clk); while (o_in_stall);
        if (sb.note_accepted_item(it))
            items_done++;
    endtask

    function automatic t_sched_item make_load(input logic [IDX_W-1:0] slot,
                                              input logic [VAL_W-1:0] period,
                                              input logic [VAL_W-1:0] work,
                                              input logic [VAL_W-1:0] deadline,
                                              input logic [VAL_W-1:0] first_release);
        t_sched_item it;
        it.opcode        = OP_LOAD;
        it.slot          = slot;
        it.period        = period;
        it.work          = work;
        it.deadline      = deadline;
        it.first_release = first_release;
        return it;
    endfunction

    // A task with a short period, light work and a first release close to the
    // current time, so that it actually takes part in scheduling soon.
    function automatic t_sched_item shaped_load(input logic [IDX_W-1:0] slot);
        int p;
        int w;
        p = $urandom_range(2, 24);
        w = $urandom_range(1, (p + 2) / 3);
        return make_load(slot, VAL_W'(p), VAL_W'(w), VAL_W'($urandom_range(w, 2 * p)),
                         sb.st.now[VAL_W-1:0] + VAL_W'($urandom_range(0, p)));
    endfunction

    // A tick whose unused fields carry random bits, or a fresh load of the slot where it would miss.
    task automatic issue_tick();
        t_sched_item it;
        t_rmts_res   outcome;
        it.opcode        = OP_TICK;
        it.slot          = IDX_W'($urandom);
        it.period        = VAL_W'($urandom);
        it.work          = VAL_W'($urandom);
        it.deadline      = VAL_W'($urandom);
        it.first_release = VAL_W'($urandom);
        if (avoid_halt) begin
            outcome = sb.preview(it);
            if (outcome.missed)
                it = shaped_load(outcome.missed_task);
        end
        push_item(it);
    endtask

    // Stops offering items until every predicted result has been seen.
    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    // Writes both registers; called only while the block is idle.
    task automatic program_regs(input logic [CNT_W-1:0] active,
                                input logic [TIME_W-1:0] horizon);
        logic              idx;
        logic [TIME_W-1:0] val;
        for (int r = 0; r < 2; r++) begin
            idx = (r == 0) ? REG_ACTIVE_TASKS : REG_HORIZON;
            val = (r == 0) ? {{(TIME_W-CNT_W){1'b0}}, active} : horizon;
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx;
            i_cfg_data  <= val;
            do @(posedge i_clk); while (!o_cfg_ready);
            sb.write_reg(idx, val);
        end
        i_cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Result side: checks each transfer and plans the next stall. The stall
    // pattern switches among random modes, and a requested hold-off keeps the
    // output blocked long enough for the input to back up.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            seen_report.tick_time    = o_tick_time;
            seen_report.ran          = o_ran;
            seen_report.ran_task     = o_ran_task;
            seen_report.job_finished = o_job_finished;
            seen_report.missed       = o_missed;
            seen_report.missed_task  = o_missed_task;
            seen_report.stopped      = o_stopped;
            sb.check_tick_result(seen_report);
        end
        if (hold_requests != hold_seen) begin
            hold_seen++;
            hold_left = HOLD_OFF_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            if (mode_left == 0) begin
                stall_mode = $urandom_range(0, 3);
                mode_left = $urandom_range(16, 96);
            end else begin
                mode_left--;
            end
            case (stall_mode)
                0: i_out_stall <= 1'b0;
                1: i_out_stall <= ($urandom_range(0, 3) == 0);
                2: i_out_stall <= ($urandom_range(0, 3) != 0);
                default: i_out_stall <= ~i_out_stall;
            endcase
        end
    end

    // Watchdog: any transfer on any channel counts as progress.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("[rate_monotonic_tick_scheduler_core] ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus sequence
    // ------------------------------------------------------------------
    initial begin
        int          phase;
        int          left;
        int          burst;
        int          pick;
        int          sel;
        bit          gappy;
        logic [CNT_W-1:0]  active;
        logic [TIME_W-1:0] horizon;
        logic [VAL_W-1:0]  base;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part. With no active tasks a tick is idle but time moves on.
        issue_tick();
        issue_tick();

        // Fill the whole table before any slot becomes active. Slots 0 and 1
        // share a period to exercise the lower-index tie break, slot 2 holds
        // every field at its maximum and slot 3 at its minimum; slot 2 has its
        // first release far ahead and slot 3 already in the past, so both stay
        // dormant.
        push_item(make_load(0, 6, 1, 6, 4));
        push_item(make_load(1, 6, 2, 6, 4));
        push_item(make_load(2, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        push_item(make_load(3, 1, 1, 1, 0));
        push_item(make_load(4, 12, 2, 12, 5));
        push_item(make_load(5, 20, 2, 7, 6));
        push_item(make_load(6, 9, 1, 2, 8));
        push_item(make_load(7, 30, 2, 30, 3));

        // An oversized active count saturates to the full table.
        drain();
        program_regs('1, '1);
        repeat (10) issue_tick();

        // A horizon two ticks ahead: two ticks run, the rest are ignored.
        drain();
        program_regs(CNT_W'(MAX_TASKS), sb.st.now + 2);
        repeat (4) issue_tick();

        // Horizon zero ignores every tick.
        drain();
        program_regs(CNT_W'(MAX_TASKS), '0);
        repeat (2) issue_tick();

        // Random part: phases of bursty traffic, each with its own register
        // setting. Every phase starts from an idle block, which also gives the
        // sender a pause until all results are back.
        phase = 0;
        while (items_done < ITEM_TARGET) begin
            drain();
            sel = $urandom_range(0, 9);
            if (sel == 0)
                active = '0;
            else if (sel == 1)
                active = '1;
            else if (sel == 2)
                active = CNT_W'($urandom_range(MAX_TASKS + 1, 15));
            else
                active = CNT_W'($urandom_range(1, MAX_TASKS));
            sel = $urandom_range(0, 9);
            if (sel == 0)
                horizon = sb.st.now + $urandom_range(0, 40);
            else if (sel == 1)
                horizon = $urandom | 32'h8000_0000;
            else
                horizon = '1;
            program_regs(active, horizon);

            // Once, the output is blocked for a long stretch while items keep
            // coming, so the block fills up and stalls its input.
            if (phase == 1)
                hold_requests <= hold_requests + 1;

            gappy = ($urandom_range(0, 3) != 0);
            left = $urandom_range(80, 250);
            while (left > 0) begin
                burst = $urandom_range(1, 40);
                while (burst > 0 && left > 0) begin
                    pick = $urandom_range(0, 99);
                    if (pick < 78)
                        issue_tick();
                    else if (pick < 95)
                        push_item(shaped_load(IDX_W'($urandom_range(0, MAX_TASKS - 1))));
                    else
                        push_item(make_load(IDX_W'($urandom),
                                            VAL_W'($urandom_range(1, 16'hFFFF)),
                                            VAL_W'($urandom_range(1, 16'hFFFF)),
                                            VAL_W'($urandom_range(1, 16'hFFFF)),
                                            VAL_W'($urandom)));
                    burst--;
                    left--;
                end
                if (gappy) begin
                    i_in_valid <= 1'b0;
                    repeat ($urandom_range(1, 12)) @(posedge i_clk);
                end
            end
            phase++;
        end

        // Closing part: a deliberate deadline miss, chosen at random between a
        // job still unfinished at its next release and a pending job that
        // waits past its deadline behind a higher-priority task.
        drain();
        program_regs(2, '1);
        avoid_halt = 1'b0;
        base = sb.st.now[VAL_W-1:0];
        if ($urandom_range(0, 1) == 0) begin
            // Slot 1 needs three ticks every two; slot 0 is released just
            // before it in the scan when the second release of slot 1 fails.
            push_item(make_load(0, 50, 1, 50, base + VAL_W'(2)));
            push_item(make_load(1, 2, 3, 100, base));
        end else begin
            // Slot 0 runs three ticks first; slot 1 reaches its deadline
            // of three ticks with all of its work left.
            push_item(make_load(0, 5, 3, 5, base));
            push_item(make_load(1, 10, 2, 3, base));
        end
        for (int k = 0; k < 20 && !sb.st.halted; k++)
            issue_tick();

        // Once halted, ticks are ignored and loads are still taken.
        repeat (3) issue_tick();
        push_item(shaped_load(IDX_W'($urandom_range(0, MAX_TASKS - 1))));

        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        sb.close_out();
        if (sb.failures == 0)
            $display("[rate_monotonic_tick_scheduler_core] OK");
        else
            $display("[rate_monotonic_tick_scheduler_core] ERROR");
        $finish;
    end

endmodule
